// ===== hdl/bpr_pkg.sv =====
// Shared types and constants for the BPR link travel time block.
// Used by bpr_div_cell, bpr_link_travel_time and the testbench; depends on nothing else.
package bpr_pkg;

	localparam int MAX_EXPONENT = 4;
	localparam int FLOW_BITS    = 16;

	localparam int NUM_W  = 103;
	localparam int DEN_W  = 71;
	localparam int QUO_W  = 32;
	localparam int FT_W   = 24;
	localparam int COST_W = 31;

	localparam logic [15:0] FLOW_MAX = 16'((32'd1 << FLOW_BITS) - 32'd1);
	localparam logic [2:0]  BETA_MAX = 3'(MAX_EXPONENT);
	localparam logic [6:0]  PCT_SCALE = 7'd100;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [1:0] CFG_ALPHA = 2'd0;
	localparam logic [1:0] CFG_BETA  = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic [FT_W-1:0]  ft;
	} div_t;

endpackage

// ===== hdl/bpr_link_travel_time.sv =====
// BPR link travel time: one item per cycle while the output is not stalled; a
// stalled output lets bubbles ahead fill first. The pipeline is five operand
// stages, the 32-cell divider chain (one quotient bit per cell) and the output
// register. Reset (asynchronous, active low) empties the pipeline and loads the
// register defaults: alpha 15 hundredths, exponent 4, no travel time clamp.
module bpr_link_travel_time #(
	parameter int MAX_EXPONENT = bpr_pkg::MAX_EXPONENT,
	parameter int FLOW_BITS    = bpr_pkg::FLOW_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] free_time,
	input  logic [15:0] link_capacity,
	input  logic signed [16:0] link_flow,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] trip_time
);

	// Saturation limits for the flow and the exponent.
	localparam logic [15:0] FLOW_LIM = 16'((32'd1 << FLOW_BITS) - 32'd1);
	localparam logic [2:0]  BETA_LIM = 3'(MAX_EXPONENT);

	// Configuration registers: the user changes them only while the block is idle
	// (not enforced); the pipeline reads them directly at whichever stage needs them.
	logic [13:0] alpha_q;
	logic [2:0]  beta_q;
	logic [30:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 14'd15;
			beta_q  <= 3'd4;
			limit_q <= 31'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpr_pkg::CFG_ALPHA: alpha_q <= cfg_data[13:0];
				bpr_pkg::CFG_BETA:  beta_q  <= cfg_data[2:0];
				bpr_pkg::CFG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage advances when it is empty or when the stage after it advances,
	// so a stall at the output only halts the occupied stages behind it.
	logic en1, en2, en3, en4, en5, en_o;
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic [32:0] cv;
	logic [32:0] ce;
	bpr_pkg::div_t cd [33];

	assign en_o     = !out_valid || out_ready;
	assign ce[32]   = en_o;
	assign en5      = !v5_q || ce[0];
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (en1) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	// Stage 1: clean up the operands, form free_time*alpha and the squares.
	logic [15:0] flow_n, cap_n;
	logic [2:0]  beta_n;

	always_comb begin
		if (link_flow[16]) begin
			flow_n = 16'd0;
		end else if (link_flow[15:0] > FLOW_LIM) begin
			flow_n = FLOW_LIM;
		end else begin
			flow_n = link_flow[15:0];
		end
		cap_n  = (link_capacity == 16'd0) ? 16'd1 : link_capacity;
		beta_n = (beta_q > BETA_LIM) ? BETA_LIM : beta_q;
	end

	logic [37:0] p1_s1;
	logic [15:0] f_s1, c_s1;
	logic [31:0] f2_s1, c2_s1;
	logic [2:0]  beta_s1;
	logic [23:0] ft_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			p1_s1   <= 38'(free_time) * 38'(alpha_q);
			f_s1    <= flow_n;
			c_s1    <= cap_n;
			f2_s1   <= 32'(flow_n) * 32'(flow_n);
			c2_s1   <= 32'(cap_n) * 32'(cap_n);
			beta_s1 <= beta_n;
			ft_s1   <= free_time;
		end
	end

	// Stage 2: pick the power of flow and of capacity for the exponent.
	logic [63:0] fpow, cpow;

	always_comb begin
		case (beta_s1)
			3'd0: begin
				fpow = 64'd1;
				cpow = 64'd1;
			end
			3'd1: begin
				fpow = 64'(f_s1);
				cpow = 64'(c_s1);
			end
			3'd2: begin
				fpow = 64'(f2_s1);
				cpow = 64'(c2_s1);
			end
			3'd3: begin
				fpow = 64'(f2_s1) * 64'(f_s1);
				cpow = 64'(c2_s1) * 64'(c_s1);
			end
			default: begin
				fpow = 64'(f2_s1) * 64'(f2_s1);
				cpow = 64'(c2_s1) * 64'(c2_s1);
			end
		endcase
	end

	logic [63:0] fp_s2, cp_s2;
	logic [37:0] p1_s2;
	logic [23:0] ft_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			fp_s2 <= fpow;
			cp_s2 <= cpow;
			p1_s2 <= p1_s1;
			ft_s2 <= ft_s1;
		end
	end

	// Stage 3: numerator as two partial products, denominator times 100.
	logic [69:0] plo_s3, phi_s3;
	logic [70:0] den_s3;
	logic [23:0] ft_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			plo_s3 <= 70'(p1_s2) * 70'(fp_s2[31:0]);
			phi_s3 <= 70'(p1_s2) * 70'(fp_s2[63:32]);
			den_s3 <= 71'(cp_s2) * 71'(bpr_pkg::PCT_SCALE);
			ft_s3  <= ft_s2;
		end
	end

	// Stage 4: combine the partial products into the full numerator.
	logic [102:0] num_s4;
	logic [70:0]  den_s4;
	logic [23:0]  ft_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			num_s4 <= 103'(plo_s3) + (103'(phi_s3) << 32);
			den_s4 <= den_s3;
			ft_s4  <= ft_s3;
		end
	end

	// Stage 5: bias the numerator by den-1 so the truncating divide rounds up.
	bpr_pkg::div_t d5_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			d5_s5.rem <= num_s4 + 103'(den_s4) - 103'd1;
			d5_s5.den <= den_s4;
			d5_s5.quo <= '0;
			d5_s5.ft  <= ft_s4;
		end
	end

	assign cv[0] = v5_q;
	assign cd[0] = d5_s5;

	// Divider chain: the first cell tests the quotient against 2^31, which
	// flags a saturated penalty; the rest resolve bits 30 down to 0.
	for (genvar i = 0; i < 32; i++) begin : g_cell
		assign ce[i] = !cv[i+1] || ce[i+1];
		bpr_div_cell #(
			.SHIFT(31 - i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (ce[i]),
			.in_v  (cv[i]),
			.in_d  (cd[i]),
			.out_v (cv[i+1]),
			.out_d (cd[i+1])
		);
	end

	// Output stage: add free time, saturate, then apply the optional clamp.
	logic [31:0] penalty;
	logic [32:0] total;
	logic [30:0] sat, res;

	always_comb begin
		penalty = cd[32].quo[31] ? 32'h8000_0000 : {1'b0, cd[32].quo[30:0]};
		total   = 33'(cd[32].ft) + 33'(penalty);
		sat     = (total > 33'(bpr_pkg::COST_MAX)) ? bpr_pkg::COST_MAX : total[30:0];
		res     = (limit_q != 31'd0 && sat > limit_q) ? limit_q : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_o) begin
			out_valid <= cv[32];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			trip_time <= res;
		end
	end

endmodule

// ===== hdl/bpr_div_cell.sv =====
// One step of the restoring divider chain: resolves a single quotient bit.
// Depends on bpr_pkg for the div_t carrier type.
module bpr_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_v,
	input  bpr_pkg::div_t in_d,
	output logic         out_v,
	output bpr_pkg::div_t out_d
);

	logic [bpr_pkg::NUM_W-1:0] dsh;
	logic                      fits;
	bpr_pkg::div_t             nxt;

	always_comb begin
		dsh  = bpr_pkg::NUM_W'(in_d.den) << SHIFT;
		fits = in_d.rem >= dsh;
		nxt  = in_d;
		if (fits) begin
			nxt.rem        = in_d.rem - dsh;
			nxt.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (adv) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d <= nxt;
		end
	end

endmodule

// ===== tb/sv/bpr_travel_checker.sv =====
`timescale 1ns / 1ps
// Checker for the BPR link travel time block: watches the input and output transfers,
// predicts each travel time in wide integer arithmetic and compares. Depends on bpr_pkg.
module bpr_travel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [23:0] free_time,
	input  logic [15:0] link_capacity,
	input  logic signed [16:0] link_flow,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [30:0] trip_time,
	output int          fail_count,
	output int          pending
);

	logic [13:0] alpha_reg;
	logic [2:0]  beta_reg;
	logic [30:0] limit_reg;
	logic [30:0] travel_due[$];

	function automatic logic [30:0] congested_time(logic [23:0] ft, logic [15:0] cap_in,
			logic [16:0] flow_in);
		logic [127:0] num, den, quo;
		logic [15:0]  cap, flow;
		logic [2:0]   beta;
		logic [63:0]  total;
		logic [31:0]  penalty;
		cap = (cap_in == 16'd0) ? 16'd1 : cap_in;
		flow = flow_in[16] ? 16'd0 : flow_in[15:0];
		if (flow > bpr_pkg::FLOW_MAX)
			flow = bpr_pkg::FLOW_MAX;
		beta = (beta_reg > bpr_pkg::BETA_MAX) ? bpr_pkg::BETA_MAX : beta_reg;
		num = 128'(ft) * 128'(alpha_reg);
		den = 128'd100;
		for (int k = 0; k < beta; k++) begin
			num = num * 128'(flow);
			den = den * 128'(cap);
		end
		quo = (num + den - 128'd1) / den;
		penalty = (quo > 128'h7FFF_FFFF) ? 32'h8000_0000 : quo[31:0];
		total = 64'(ft) + 64'(penalty);
		if (total > 64'h7FFF_FFFF)
			total = 64'h7FFF_FFFF;
		if (limit_reg != 31'd0 && total > 64'(limit_reg))
			total = 64'(limit_reg);
		return total[30:0];
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = travel_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_reg = 14'd15;
			beta_reg = 3'd4;
			limit_reg = 31'd0;
		end else begin
			// The block samples configuration and inputs at the same edge, so update first
			// only for writes, which never coincide with traffic.
			if (cfg_we) begin
				case (cfg_index)
					bpr_pkg::CFG_ALPHA: alpha_reg = cfg_data[13:0];
					bpr_pkg::CFG_BETA:  beta_reg = cfg_data[2:0];
					bpr_pkg::CFG_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (travel_due.size() == 0)
					report_mismatch("trip_time transfer with none expected");
				else begin
					logic [30:0] want;
					want = travel_due.pop_front();
					if (trip_time !== want)
						report_mismatch($sformatf("trip_time got %0d want %0d",
							trip_time, want));
				end
			end
			if (in_valid && in_ready)
				travel_due = {travel_due,
					congested_time(free_time, link_capacity, link_flow)};
		end
	end
endmodule

// ===== tb/sv/bpr_link_travel_time_test.sv =====
`timescale 1ns / 1ps
// Top of the BPR link travel time testbench: clock, reset, configuration, stimulus and verdict.
// Depends on bpr_pkg, bpr_link_travel_time and bpr_travel_checker.
module bpr_link_travel_time_test;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [23:0] free_time;
	logic [15:0] link_capacity;
	logic signed [16:0] link_flow;
	logic        out_valid;
	logic        out_ready;
	logic [30:0] trip_time;
	int          fail_count;
	int          pending;
	int          cycle_count;
	// Idle percentages for the two sides; zero during the stretch with no idling.
	int          send_idle_pct;
	int          recv_idle_pct;
	// When set, the receiver holds off completely for a long stretch.
	logic        hold_off;

	bpr_link_travel_time dut (.*);

	bpr_travel_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The watchdog allows far more than the slowest correct run: about 1300 transfers
	// each with idle gaps on both sides, the hold-off, and the pipeline latency.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver: ready changes only at the falling edge.
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_reg(logic [1:0] idx, logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Send one transfer: valid rises at a falling edge and stays until accepted.
	// Valid drops only while the sender idles or drains.
	task automatic send_link(logic [23:0] ft, logic [15:0] cap, logic [16:0] flow);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		free_time <= ft;
		link_capacity <= cap;
		link_flow <= flow;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Wait until all results are back, then let the pipeline drain fully.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	// Mostly small, realistic links; sometimes full-range fields.
	task automatic send_random_link;
		logic [23:0] ft;
		logic [15:0] cap;
		logic [16:0] flow;
		if ($urandom_range(3) == 0) begin
			ft = 24'($urandom);
			cap = 16'($urandom);
			flow = 17'($urandom);
		end else begin
			ft = 24'($urandom_range(5000));
			cap = 16'($urandom_range(2000));
			flow = 17'($urandom_range(3000));
			if ($urandom_range(9) == 0)
				flow = -flow;
		end
		send_link(ft, cap, flow);
	endtask

	initial begin
		cycle_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bpr_pkg::CFG_ALPHA;
		cfg_data = '0;
		in_valid = 1'b0;
		free_time = '0;
		link_capacity = '0;
		link_flow = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 26;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed transfers at the reset settings: extremes, zero capacity,
		// negative flow, and a huge penalty that saturates the sum.
		send_link(24'd0, 16'd0, 17'd0);
		send_link(24'hFFFFFF, 16'd0, 17'h0FFFF);
		send_link(24'hFFFFFF, 16'hFFFF, 17'h0FFFF);
		send_link(24'd1000, 16'd100, 17'h10000);
		send_link(24'd1000, 16'd100, -17'sd1);
		send_link(24'd1000, 16'd100, 17'd100);
		send_link(24'd1, 16'd1, 17'd1);
		send_link(24'd600, 16'd1200, 17'd1500);
		drain();

		// Exponent zero, alpha at and above its nominal maximum, clamp at extremes.
		write_reg(bpr_pkg::CFG_BETA, 31'd0);
		write_reg(bpr_pkg::CFG_ALPHA, 31'd10000);
		write_reg(bpr_pkg::CFG_LIMIT, 31'h7FFFFFFF);
		send_link(24'hFFFFFF, 16'd5, 17'd7);
		send_link(24'd3, 16'd0, 17'd0);
		drain();
		write_reg(bpr_pkg::CFG_ALPHA, 31'h3FFF);
		write_reg(bpr_pkg::CFG_LIMIT, 31'd1);
		send_link(24'd12345, 16'd9, 17'd9);
		send_link(24'd0, 16'd9, 17'd9);
		drain();
		// Exponent above the maximum saturates to it.
		write_reg(bpr_pkg::CFG_BETA, 31'd7);
		write_reg(bpr_pkg::CFG_LIMIT, 31'd0);
		write_reg(bpr_pkg::CFG_ALPHA, 31'd0);
		send_link(24'd777, 16'd10, 17'd40);
		drain();
		write_reg(bpr_pkg::CFG_ALPHA, 31'd15);
		send_link(24'd777, 16'd10, 17'd40);
		send_link(24'd50, 16'd1, 17'h0FFFF);
		drain();

		// Random phases, each with a fresh setting; the first has no idling at all.
		for (int phase = 0; phase < 10; phase++) begin
			send_idle_pct = (phase == 0) ? 0 : 26;
			recv_idle_pct = (phase == 0) ? 0 : 26;
			write_reg(bpr_pkg::CFG_ALPHA, (phase % 3 == 0) ? 31'($urandom_range(10000))
				: 31'($urandom_range(200)));
			write_reg(bpr_pkg::CFG_BETA, 31'($urandom_range(7)));
			write_reg(bpr_pkg::CFG_LIMIT, ($urandom_range(2) == 0)
				? 31'($urandom_range(100000)) : 31'd0);
			if (phase == 3) begin
				// Long receiver hold-off while the sender keeps offering, so the
				// pipeline fills and input ready drops.
				fork
					begin
						@(negedge clk);
						hold_off = 1'b1;
						repeat (300) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int n = 0; n < 128; n++)
				send_random_link();
			drain();
		end

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== bpr_link_travel_time.f =====
hdl/bpr_pkg.sv
hdl/bpr_div_cell.sv
hdl/bpr_link_travel_time.sv
tb/sv/bpr_travel_checker.sv
tb/sv/bpr_link_travel_time_test.sv
